FILE: rtl/core/msaa_framebuffer_resolve_core_assert.svh
// Assertion macros shared by the resolve core.
`ifndef MSAA_FRAMEBUFFER_RESOLVE_CORE_ASSERT_SVH
`define MSAA_FRAMEBUFFER_RESOLVE_CORE_ASSERT_SVH

// Same-cycle implication, checked while reset is low.
`define MFR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked while reset is low.
`define MFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/msaa_pkg.sv
`default_nettype none
package msaa_pkg;
   localparam int SAMPLES = 4;
   localparam int COLOR_W = 32;
   localparam int DEPTH_W = 24;
   localparam logic [DEPTH_W-1:0] DEPTH_ONES = '1;

   typedef enum logic [3:0] {
      CMD_CLR_COLOR   = 4'd0,
      CMD_CLR_DEPTH   = 4'd1,
      CMD_SET_PIXEL   = 4'd2,
      CMD_SET_DEPTH   = 4'd3,
      CMD_SET_SCOLOR  = 4'd4,
      CMD_SET_SDEPTH  = 4'd5,
      CMD_GET_PIXEL   = 4'd6,
      CMD_GET_DEPTH   = 4'd7,
      CMD_GET_SCOLOR  = 4'd8,
      CMD_GET_SDEPTH  = 4'd9,
      CMD_RESOLVE     = 4'd10
   } cmd_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_DRAIN,
      ST_OUT
   } state_type;

   typedef logic [SAMPLES-1:0][COLOR_W-1:0] color_row_type;
   typedef logic [SAMPLES-1:0][DEPTH_W-1:0] depth_row_type;
endpackage
`default_nettype wire

FILE: rtl/core/msaa_framebuffer_resolve_core.sv
// Channel   Handshake              Payload
// req       req_valid/req_ready    command, pos_x, pos_y, sample_sel, color_in, depth_in
// rsp       rsp_valid/rsp_ready    color_out, depth_out, in_range
// csr       csr_we                 csr_index, csr_wdata
// Pixel and sample commands pass through memory read, modify and write, and result.
// Clears sweep all MAX_WIDTH*MAX_HEIGHT pixels; resolve sweeps width*height pixels,
// one pixel of the sample memory read per cycle.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT pixels runs with req_ready low.
// A transaction is accepted while an earlier result waits in the output register;
// a new result waits until that register is taken.
`default_nettype none
module msaa_framebuffer_resolve_core import msaa_pkg::*; #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_command,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic [2:0]         req_sample_sel,
   input  wire logic [31:0]        req_color_in,
   input  wire logic [23:0]        req_depth_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_color_out,
   output logic [23:0]             rsp_depth_out,
   output logic                    rsp_in_range,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [9:0]         csr_wdata
);
   `include "msaa_framebuffer_resolve_core_assert.svh"

   localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int YW = $clog2(MAX_HEIGHT + 1);

   logic [DEPTH_W+COLOR_W-1:0]           pix_mem [PIXELS];
   logic [SAMPLES*(DEPTH_W+COLOR_W)-1:0] samp_mem [PIXELS];

   state_type state_ff, state_in;
   logic [9:0] width_ff, height_ff;
   logic init_ff, init_in;
   logic pend_ff;
   logic [AW-1:0] pend_addr_ff;
   logic [XW-1:0] cx_ff, cx_in, lim_x_ff, lim_x_in;
   logic [YW-1:0] cy_ff, cy_in, lim_y_ff, lim_y_in;
   cmd_type cmd_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [1:0] sel_ff;
   logic pos_ok_ff, samp_ok_ff;
   logic [AW-1:0] pix_ff;
   logic [COLOR_W-1:0] res_color_ff, res_color_in;
   logic [DEPTH_W-1:0] res_depth_ff, res_depth_in;
   logic res_ok_ff, res_ok_in;
   logic rsp_valid_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic [DEPTH_W-1:0] rsp_depth_ff;
   logic rsp_ok_ff;

   logic [COLOR_W-1:0] pc_rd;
   logic [DEPTH_W-1:0] pd_rd;
   color_row_type sc_rd, sc_new;
   depth_row_type sd_rd, sd_new;

   logic [9:0] used_w, used_h;
   logic req_pos_ok, req_samp_ok, accept, last, rsp_load;
   logic [AW-1:0] req_addr, sweep_addr, raddr, waddr;
   logic pc_we, pd_we, sc_we, sd_we;
   logic [COLOR_W-1:0] pc_wd, mean;
   logic [DEPTH_W-1:0] pd_wd, min_new, min_rd;
   color_row_type sc_wd;
   depth_row_type sd_wd;
   logic [9:0] ch_sum;
   logic [DEPTH_W-1:0] m01, m23, n01, n23;

   assign used_w = ({6'd0, width_ff} > 16'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : width_ff;
   assign used_h = ({6'd0, height_ff} > 16'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : height_ff;
   assign req_pos_ok = (req_pos_x < 0 ? 1'b0 : (16'(req_pos_x) < {6'd0, used_w}))
                    && (req_pos_y < 0 ? 1'b0 : (16'(req_pos_y) < {6'd0, used_h}));
   assign req_samp_ok = req_pos_ok && (req_sample_sel < 3'(SAMPLES));
   assign req_addr = req_pos_ok ?
      AW'(int'(req_pos_y[YW-1:0]) * MAX_WIDTH + int'(req_pos_x[XW-1:0])) : '0;
   assign sweep_addr = AW'(int'(cy_ff) * MAX_WIDTH + int'(cx_ff));
   assign last = (cx_ff == lim_x_ff - XW'(1)) && (cy_ff == lim_y_ff - YW'(1));
   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign raddr = (state_ff == ST_IDLE) ? req_addr : sweep_addr;
   assign waddr = (state_ff == ST_EXEC) ? pix_ff : pend_addr_ff;

   always_comb begin
      sc_new = sc_rd;
      sd_new = sd_rd;
      sc_new[sel_ff] = color_ff;
      sd_new[sel_ff] = depth_ff;
      n01 = (sd_new[0] < sd_new[1]) ? sd_new[0] : sd_new[1];
      n23 = (sd_new[2] < sd_new[3]) ? sd_new[2] : sd_new[3];
      min_new = (n01 < n23) ? n01 : n23;
      m01 = (sd_rd[0] < sd_rd[1]) ? sd_rd[0] : sd_rd[1];
      m23 = (sd_rd[2] < sd_rd[3]) ? sd_rd[2] : sd_rd[3];
      min_rd = (m01 < m23) ? m01 : m23;
      mean = '0;
      for (int ch = 0; ch < 4; ch++) begin
         ch_sum = 10'd2;
         for (int s = 0; s < SAMPLES; s++) begin
            ch_sum = ch_sum + {2'd0, sc_rd[s][ch*8 +: 8]};
         end
         mean[ch*8 +: 8] = ch_sum[9:2];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_CLR_COLOR || req_command == CMD_CLR_DEPTH) begin
                  state_in = ST_SWEEP;
               end else if (req_command == CMD_RESOLVE) begin
                  state_in = (used_w == '0 || used_h == '0) ? ST_OUT : ST_SWEEP;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC:  state_in = ST_OUT;
         ST_SWEEP: if (last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = init_ff ? ST_IDLE : ST_OUT;
         ST_OUT:   if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      init_in = init_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      lim_x_in = lim_x_ff;
      lim_y_in = lim_y_ff;
      res_color_in = res_color_ff;
      res_depth_in = res_depth_ff;
      res_ok_in = res_ok_ff;
      pc_we = 1'b0;
      pd_we = 1'b0;
      sc_we = 1'b0;
      sd_we = 1'b0;
      pc_wd = color_ff;
      pd_wd = depth_ff;
      sc_wd = {SAMPLES{color_ff}};
      sd_wd = {SAMPLES{depth_ff}};
      case (state_ff)
         ST_IDLE: begin
            cx_in = '0;
            cy_in = '0;
            res_color_in = '0;
            res_depth_in = '0;
            res_ok_in = 1'b1;
            if (req_command == CMD_RESOLVE) begin
               lim_x_in = XW'(used_w);
               lim_y_in = YW'(used_h);
            end else begin
               lim_x_in = XW'(MAX_WIDTH);
               lim_y_in = YW'(MAX_HEIGHT);
            end
         end
         ST_EXEC: begin
            res_ok_in = 1'b0;
            case (cmd_ff)
               CMD_SET_PIXEL: begin
                  res_ok_in = pos_ok_ff;
                  pc_we = pos_ok_ff;
                  sc_we = pos_ok_ff;
               end
               CMD_SET_DEPTH: begin
                  res_ok_in = pos_ok_ff;
                  pd_we = pos_ok_ff;
                  sd_we = pos_ok_ff;
               end
               CMD_SET_SCOLOR: begin
                  res_ok_in = samp_ok_ff;
                  sc_we = samp_ok_ff;
                  sc_wd = sc_new;
               end
               CMD_SET_SDEPTH: begin
                  res_ok_in = samp_ok_ff;
                  sd_we = samp_ok_ff;
                  sd_wd = sd_new;
                  pd_we = samp_ok_ff;
                  pd_wd = min_new;
               end
               CMD_GET_PIXEL: begin
                  res_ok_in = pos_ok_ff;
                  res_color_in = pos_ok_ff ? pc_rd : '0;
               end
               CMD_GET_DEPTH: begin
                  res_ok_in = pos_ok_ff;
                  res_depth_in = pos_ok_ff ? pd_rd : DEPTH_ONES;
               end
               CMD_GET_SCOLOR: begin
                  res_ok_in = samp_ok_ff;
                  res_color_in = samp_ok_ff ? sc_rd[sel_ff] : '0;
               end
               CMD_GET_SDEPTH: begin
                  res_ok_in = samp_ok_ff;
                  res_depth_in = samp_ok_ff ? sd_rd[sel_ff] : DEPTH_ONES;
               end
               default: res_ok_in = 1'b0;
            endcase
         end
         ST_SWEEP, ST_DRAIN: begin
            if (state_ff == ST_SWEEP) begin
               if (cx_ff == lim_x_ff - XW'(1)) begin
                  cx_in = '0;
                  cy_in = cy_ff + YW'(1);
               end else begin
                  cx_in = cx_ff + XW'(1);
               end
            end else begin
               init_in = 1'b0;
            end
            if (init_ff) begin
               pc_we = pend_ff;
               pd_we = pend_ff;
               sc_we = pend_ff;
               sd_we = pend_ff;
               pc_wd = '0;
               pd_wd = DEPTH_ONES;
               sc_wd = '0;
               sd_wd = {SAMPLES{DEPTH_ONES}};
            end else if (cmd_ff == CMD_RESOLVE) begin
               pc_we = pend_ff;
               pd_we = pend_ff;
               pc_wd = mean;
               pd_wd = min_rd;
            end else if (cmd_ff == CMD_CLR_COLOR) begin
               pc_we = pend_ff;
               sc_we = pend_ff;
            end else begin
               pd_we = pend_ff;
               sd_we = pend_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         init_ff <= 1'b1;
         pend_ff <= 1'b0;
         cx_ff <= '0;
         cy_ff <= '0;
         lim_x_ff <= XW'(MAX_WIDTH);
         lim_y_ff <= YW'(MAX_HEIGHT);
         width_ff <= 10'd512;
         height_ff <= 10'd512;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff <= init_in;
         pend_ff <= (state_ff == ST_SWEEP);
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         lim_x_ff <= lim_x_in;
         lim_y_ff <= lim_y_in;
         if (csr_we && csr_index == CSR_WIDTH) width_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_HEIGHT) height_ff <= csr_wdata;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= sweep_addr;
      res_color_ff <= res_color_in;
      res_depth_ff <= res_depth_in;
      res_ok_ff <= res_ok_in;
      if (accept) begin
         cmd_ff <= cmd_type'(req_command);
         color_ff <= req_color_in;
         depth_ff <= req_depth_in;
         sel_ff <= req_sample_sel[1:0];
         pos_ok_ff <= req_pos_ok;
         samp_ok_ff <= req_samp_ok;
         pix_ff <= req_addr;
      end
      if (rsp_load) begin
         rsp_color_ff <= res_color_ff;
         rsp_depth_ff <= res_depth_ff;
         rsp_ok_ff <= res_ok_ff;
      end
   end

   // A half that is not written keeps the value read from the same entry.
   always_ff @(posedge clock) begin
      if (pc_we || pd_we) begin
         pix_mem[waddr] <= {(pd_we ? pd_wd : pd_rd), (pc_we ? pc_wd : pc_rd)};
      end
      {pd_rd, pc_rd} <= pix_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (sc_we || sd_we) begin
         samp_mem[waddr] <= {(sd_we ? sd_wd : sd_rd), (sc_we ? sc_wd : sc_rd)};
      end
      {sd_rd, sc_rd} <= samp_mem[raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_color_out = rsp_color_ff;
   assign rsp_depth_out = rsp_depth_ff;
   assign rsp_in_range = rsp_ok_ff;

   `MFR_ASSERT_NEXT(a_exec_after_accept, clock, reset,
      accept && req_command == CMD_GET_PIXEL, state_ff == ST_EXEC)
   `MFR_ASSERT_SAME(a_drain_has_write, clock, reset, state_ff == ST_DRAIN, pend_ff)
   `MFR_ASSERT_SAME(a_idle_no_pending, clock, reset, req_ready, !pend_ff && !init_ff)
   `MFR_ASSERT_NEXT(a_load_sets_valid, clock, reset, rsp_load, rsp_valid_ff)
endmodule
`default_nettype wire
